@@ rtl/core/tcc_pkg.sv @@
package tcc_pkg;

   localparam int MEM_WORDS = 1024;
   localparam int MEM_AW    = $clog2(MEM_WORDS);

   typedef struct packed {
      logic [1:0]  req_type;
      logic [9:0]  address;
      logic [31:0] write_data;
   } req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic [9:0]  pc_value;
      logic        halted;
      logic        bad_opcode;
      logic        interrupt_taken;
   } rsp_type;

   localparam logic [1:0] REQ_WRITE = 2'd0;
   localparam logic [1:0] REQ_READ  = 2'd1;
   localparam logic [1:0] REQ_IRQ   = 2'd2;
   localparam logic [1:0] REQ_STEP  = 2'd3;

   localparam logic [4:0] OP_JMP   = 5'h00;
   localparam logic [4:0] OP_JMPI  = 5'h01;
   localparam logic [4:0] OP_JMPIG = 5'h02;
   localparam logic [4:0] OP_JMPIL = 5'h03;
   localparam logic [4:0] OP_JMPIE = 5'h04;
   localparam logic [4:0] OP_ADDI  = 5'h08;
   localparam logic [4:0] OP_SUBI  = 5'h09;
   localparam logic [4:0] OP_ANDI  = 5'h0A;
   localparam logic [4:0] OP_ORI   = 5'h0B;
   localparam logic [4:0] OP_LDI   = 5'h0C;
   localparam logic [4:0] OP_LDD   = 5'h0D;
   localparam logic [4:0] OP_STD   = 5'h0E;
   localparam logic [4:0] OP_ADD   = 5'h10;
   localparam logic [4:0] OP_SUB   = 5'h11;
   localparam logic [4:0] OP_AND   = 5'h12;
   localparam logic [4:0] OP_OR    = 5'h13;
   localparam logic [4:0] OP_LDX   = 5'h14;
   localparam logic [4:0] OP_STX   = 5'h15;
   localparam logic [4:0] OP_NOT   = 5'h18;
   localparam logic [4:0] OP_SHL   = 5'h19;
   localparam logic [4:0] OP_SHR   = 5'h1A;
   localparam logic [4:0] OP_SWAP  = 5'h1B;
   localparam logic [4:0] OP_MULT  = 5'h1C;
   localparam logic [4:0] OP_STOP  = 5'h1F;

endpackage

@@ rtl/core/tcc_ram.sv @@
module tcc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

@@ rtl/core/tcc_queue.sv @@
module tcc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  tcc_pkg::req_type  in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output tcc_pkg::req_type  out_data
);
   // two-entry queue between front and back
   tcc_pkg::req_type slot_ff [2];
   logic             wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = slot_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         slot_ff[wp_ff] <= in_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 |-> !push) else $error("queue overflow");
   a_count: assert property (@(posedge clock) disable iff (reset)
      push && !pop && cnt_ff != 2'd2 |=> cnt_ff == $past(cnt_ff) + 2'd1)
      else $error("queue count");
   a_empty: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd0 |-> !pop) else $error("queue underflow");
endmodule

@@ rtl/core/tcc_exec.sv @@
module tcc_exec (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  tcc_pkg::req_type  in_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tcc_pkg::rsp_type  rsp_payload
);
   localparam int AW = tcc_pkg::MEM_AW;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_FETCH = 3'd1;
   localparam logic [2:0] ST_DEC   = 3'd2;
   localparam logic [2:0] ST_MEM   = 3'd3;
   localparam logic [2:0] ST_READ  = 3'd4;
   localparam logic [2:0] ST_MUL   = 3'd5;

   logic [2:0]       st_ff, st_in;
   logic [31:0]      rf_ff [8];
   logic [AW-1:0]    pc_ff, pc_in;
   logic             stop_ff, stop_in, irq_ff, irq_in;
   logic             ov_ff, ov_in;
   tcc_pkg::rsp_type out_ff, out_in;
   logic [31:0]      ir_ff, ir_in;
   logic [31:0]      mul_ff, mul_in;

   logic             mem_we;
   logic [AW-1:0]    mem_wa, mem_ra;
   logic [31:0]      mem_wd, mem_rd;

   logic             rf_we;
   logic [31:0]      rf_wd;

   logic [4:0]       op;
   logic [2:0]       rd, rs;
   logic [31:0]      k, a, b;

   tcc_ram #(.WIDTH(32), .DEPTH(tcc_pkg::MEM_WORDS)) u_mem (
      .clock(clock), .wr_en(mem_we), .wr_addr(mem_wa), .wr_data(mem_wd),
      .rd_addr(mem_ra), .rd_data(mem_rd)
   );

   assign op = ir_ff[31:27];
   assign rd = ir_ff[26:24];
   assign rs = ir_ff[23:21];
   assign k  = {16'd0, ir_ff[15:0]};
   assign a  = rf_ff[rd];
   assign b  = rf_ff[rs];

   // result register frees only after it is taken
   assign in_ready    = (st_ff == ST_IDLE) && (!ov_ff || rsp_ready);
   assign rsp_valid   = ov_ff;
   assign rsp_payload = out_ff;

   always_comb begin
      logic [31:0] sw;
      sw      = '0;
      st_in   = st_ff;
      pc_in   = pc_ff;
      stop_in = stop_ff;
      irq_in  = irq_ff;
      ov_in   = ov_ff && !rsp_ready;
      out_in  = out_ff;
      ir_in   = ir_ff;
      mul_in  = mul_ff;
      mem_we  = 1'b0;
      mem_wa  = in_data.address[AW-1:0];
      mem_wd  = in_data.write_data;
      mem_ra  = in_data.address[AW-1:0];
      rf_we   = 1'b0;
      rf_wd   = '0;
      unique case (st_ff)
         ST_IDLE: begin
            if (in_valid && in_ready) begin
               out_in.read_data       = '0;
               out_in.bad_opcode      = 1'b0;
               out_in.interrupt_taken = 1'b0;
               out_in.halted          = stop_ff;
               out_in.pc_value        = 10'(pc_ff);
               unique case (in_data.req_type)
                  tcc_pkg::REQ_WRITE: begin
                     mem_we = 1'b1;
                     ov_in  = 1'b1;
                  end
                  tcc_pkg::REQ_READ: st_in = ST_READ;
                  tcc_pkg::REQ_IRQ: begin
                     irq_in = 1'b1;
                     ov_in  = 1'b1;
                  end
                  default: begin
                     if (stop_ff) begin
                        ov_in = 1'b1;
                     end else if (irq_ff) begin
                        irq_in = 1'b0;
                        out_in.interrupt_taken = 1'b1;
                        ov_in = 1'b1;
                     end else begin
                        mem_ra = pc_ff;
                        st_in  = ST_FETCH;
                     end
                  end
               endcase
            end
         end
         ST_READ: begin
            out_in.read_data = mem_rd;
            ov_in = 1'b1;
            st_in = ST_IDLE;
         end
         ST_FETCH: begin
            ir_in = mem_rd;
            pc_in = pc_ff + AW'(1);
            st_in = ST_DEC;
         end
         ST_DEC: begin
            st_in = ST_IDLE;
            ov_in = 1'b1;
            unique case (op)
               tcc_pkg::OP_JMP:   pc_in = k[AW-1:0];
               tcc_pkg::OP_JMPI:  pc_in = a[AW-1:0];
               tcc_pkg::OP_JMPIG: if (b != 0 && !b[31]) pc_in = a[AW-1:0];
               tcc_pkg::OP_JMPIL: if (b[31]) pc_in = a[AW-1:0];
               tcc_pkg::OP_JMPIE: if (b == 0) pc_in = a[AW-1:0];
               tcc_pkg::OP_ADDI: begin rf_we = 1'b1; rf_wd = a + k; end
               tcc_pkg::OP_SUBI: begin rf_we = 1'b1; rf_wd = a - k; end
               tcc_pkg::OP_ANDI: begin rf_we = 1'b1; rf_wd = a & k; end
               tcc_pkg::OP_ORI:  begin rf_we = 1'b1; rf_wd = a | k; end
               tcc_pkg::OP_LDI:  begin rf_we = 1'b1; rf_wd = k; end
               tcc_pkg::OP_ADD:  begin rf_we = 1'b1; rf_wd = a + b; end
               tcc_pkg::OP_SUB:  begin rf_we = 1'b1; rf_wd = a - b; end
               tcc_pkg::OP_AND:  begin rf_we = 1'b1; rf_wd = a & b; end
               tcc_pkg::OP_OR:   begin rf_we = 1'b1; rf_wd = a | b; end
               tcc_pkg::OP_NOT:  begin rf_we = 1'b1; rf_wd = ~a; end
               tcc_pkg::OP_SHL:  begin rf_we = 1'b1; rf_wd = {a[30:0], 1'b0}; end
               tcc_pkg::OP_SHR:  begin rf_we = 1'b1; rf_wd = {a[31], a[31:1]}; end
               tcc_pkg::OP_SWAP: begin
                  sw = {a[27:24], a[31:28], a[19:16], a[23:20],
                        a[11:8], a[15:12], a[3:0], a[7:4]};
                  rf_we = 1'b1;
                  rf_wd = sw;
               end
               tcc_pkg::OP_STD: begin
                  mem_we = 1'b1; mem_wa = k[AW-1:0]; mem_wd = a;
               end
               tcc_pkg::OP_STX: begin
                  mem_we = 1'b1; mem_wa = a[AW-1:0]; mem_wd = b;
               end
               tcc_pkg::OP_LDD: begin
                  mem_ra = k[AW-1:0]; ov_in = 1'b0; st_in = ST_MEM;
               end
               tcc_pkg::OP_LDX: begin
                  mem_ra = b[AW-1:0]; ov_in = 1'b0; st_in = ST_MEM;
               end
               tcc_pkg::OP_MULT: begin
                  mul_in = a * b; ov_in = 1'b0; st_in = ST_MUL;
               end
               tcc_pkg::OP_STOP: stop_in = 1'b1;
               default: out_in.bad_opcode = 1'b1;
            endcase
            out_in.pc_value = 10'(pc_in);
            out_in.halted   = stop_in;
         end
         ST_MEM: begin
            rf_we = 1'b1; rf_wd = mem_rd; ov_in = 1'b1; st_in = ST_IDLE;
         end
         ST_MUL: begin
            rf_we = 1'b1; rf_wd = mul_ff; ov_in = 1'b1; st_in = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= ST_IDLE;
         pc_ff   <= '0;
         stop_ff <= 1'b0;
         irq_ff  <= 1'b0;
         ov_ff   <= 1'b0;
         for (int i = 0; i < 8; i++) rf_ff[i] <= '0;
      end else begin
         st_ff   <= st_in;
         pc_ff   <= pc_in;
         stop_ff <= stop_in;
         irq_ff  <= irq_in;
         ov_ff   <= ov_in;
         if (rf_we) rf_ff[rd] <= rf_wd;
      end
      out_ff <= out_in;
      ir_ff  <= ir_in;
      mul_ff <= mul_in;
   end

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      stop_ff |=> stop_ff) else $error("halt cleared");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      st_ff != ST_IDLE |-> !in_ready) else $error("accept while busy");
   a_halt_pc: assert property (@(posedge clock) disable iff (reset)
      stop_ff |=> pc_ff == $past(pc_ff)) else $error("pc moved while halted");
endmodule

@@ rtl/core/teaching_cpu_core.sv @@
// Flow: write, interrupt and halted steps answer from idle; a read goes through a
//   read state; a step fetches and decodes; loads and multiply add a memory or multiply state.
// Throughput: one item at a time in the back end.
// Reset: synchronous, clears registers, PC, halt, pending interrupt, queue.
//   Memory contents are not reset.
module teaching_cpu_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tcc_pkg::req_type  req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tcc_pkg::rsp_type  rsp_payload
);
   // front: queue takes beats; back: executor drains them
   logic             q_valid, q_ready;
   tcc_pkg::req_type q_data;

   tcc_queue u_queue (
      .clock(clock), .reset(reset),
      .in_valid(req_valid), .in_ready(req_ready), .in_data(req_payload),
      .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
   );

   tcc_exec u_exec (
      .clock(clock), .reset(reset),
      .in_valid(q_valid), .in_ready(q_ready), .in_data(q_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload)
   );
endmodule

@@ sim/tcc_checker.sv @@
module tcc_checker
   import tcc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_payload,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_payload,
   output int      fail_count,
   output int      outstanding
);

   logic [31:0] cpu_regs [8];
   logic [31:0] cpu_mem [1024];
   logic [9:0]  cpu_pc;
   logic        cpu_stopped;
   logic        cpu_irq;
   rsp_type     expected_rsp_q[$];

   initial begin
      fail_count = 0;
      foreach (cpu_mem[i]) cpu_mem[i] = '0;
   end

   assign outstanding = expected_rsp_q.size();

   // Run one instruction word; return 1 for an undefined opcode.
   function automatic logic run_instruction(input logic [31:0] word);
      logic [4:0]  op;
      logic [2:0]  rd, rs;
      logic [31:0] k, a, b;
      op = word[31:27];
      rd = word[26:24];
      rs = word[23:21];
      k  = {16'h0, word[15:0]};
      a  = cpu_regs[rd];
      b  = cpu_regs[rs];
      run_instruction = 1'b0;
      case (op)
         OP_JMP:   cpu_pc = k[9:0];
         OP_JMPI:  cpu_pc = a[9:0];
         OP_JMPIG: if ($signed(b) > 0) cpu_pc = a[9:0];
         OP_JMPIL: if (b[31]) cpu_pc = a[9:0];
         OP_JMPIE: if (b == 0) cpu_pc = a[9:0];
         OP_ADDI:  cpu_regs[rd] = a + k;
         OP_SUBI:  cpu_regs[rd] = a - k;
         OP_ANDI:  cpu_regs[rd] = a & k;
         OP_ORI:   cpu_regs[rd] = a | k;
         OP_LDI:   cpu_regs[rd] = k;
         OP_LDD:   cpu_regs[rd] = cpu_mem[k[9:0]];
         OP_STD:   cpu_mem[k[9:0]] = a;
         OP_ADD:   cpu_regs[rd] = a + b;
         OP_SUB:   cpu_regs[rd] = a - b;
         OP_AND:   cpu_regs[rd] = a & b;
         OP_OR:    cpu_regs[rd] = a | b;
         OP_LDX:   cpu_regs[rd] = cpu_mem[b[9:0]];
         OP_STX:   cpu_mem[a[9:0]] = b;
         OP_NOT:   cpu_regs[rd] = ~a;
         OP_SHL:   cpu_regs[rd] = a << 1;
         OP_SHR:   cpu_regs[rd] = {a[31], a[31:1]};
         OP_SWAP:  cpu_regs[rd] = ((a & 32'h0F0F0F0F) << 4) | ((a & 32'hF0F0F0F0) >> 4);
         OP_MULT:  cpu_regs[rd] = a * b;
         OP_STOP:  cpu_stopped = 1'b1;
         default:  run_instruction = 1'b1;
      endcase
   endfunction

   function automatic rsp_type predict_response(input req_type r);
      rsp_type e;
      logic [31:0] word;
      e = '0;
      case (r.req_type)
         REQ_WRITE: cpu_mem[r.address] = r.write_data;
         REQ_READ:  e.read_data = cpu_mem[r.address];
         REQ_IRQ:   cpu_irq = 1'b1;
         default: begin
            if (!cpu_stopped) begin
               if (cpu_irq) begin
                  cpu_irq = 1'b0;
                  e.interrupt_taken = 1'b1;
               end else begin
                  word = cpu_mem[cpu_pc];
                  cpu_pc = cpu_pc + 10'd1;
                  e.bad_opcode = run_instruction(word);
               end
            end
         end
      endcase
      e.pc_value = cpu_pc;
      e.halted   = cpu_stopped;
      return e;
   endfunction

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         foreach (cpu_regs[i]) cpu_regs[i] = '0;
         cpu_pc = '0;
         cpu_stopped = 1'b0;
         cpu_irq = 1'b0;
         expected_rsp_q.delete();
      end else begin
         // compare first: a beat can never be answered in its own cycle
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp_q.size() == 0) begin
               $error("response beat with nothing expected");
               fail_count++;
            end else begin
               e = expected_rsp_q.pop_front();
               if (rsp_payload.read_data !== e.read_data) begin
                  $error("read_data expected %h got %h", e.read_data, rsp_payload.read_data);
                  fail_count++;
               end
               if (rsp_payload.pc_value !== e.pc_value) begin
                  $error("pc_value expected %0d got %0d", e.pc_value, rsp_payload.pc_value);
                  fail_count++;
               end
               if (rsp_payload.halted !== e.halted) begin
                  $error("halted expected %b got %b", e.halted, rsp_payload.halted);
                  fail_count++;
               end
               if (rsp_payload.bad_opcode !== e.bad_opcode) begin
                  $error("bad_opcode expected %b got %b", e.bad_opcode,
                         rsp_payload.bad_opcode);
                  fail_count++;
               end
               if (rsp_payload.interrupt_taken !== e.interrupt_taken) begin
                  $error("interrupt_taken expected %b got %b", e.interrupt_taken,
                         rsp_payload.interrupt_taken);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready)
            expected_rsp_q.push_back(predict_response(req_payload));
      end
   end

endmodule

@@ sim/tb_top.sv @@
module tb_top;
   import tcc_pkg::*;

   localparam int STALL_LIMIT = 2000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;

   int      fail_count;
   int      outstanding;
   logic    idle_on = 1'b1;
   logic [9:0] last_pc = '0;
   int      stall_cycles = 0;
   int      item_count = 0;
   int      step_count = 0;
   int      irq_count = 0;
   int      mem_count = 0;

   always #6 clock = ~clock;

   teaching_cpu_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   tcc_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // Drop ready on the result side at random, ten percent of the time, unless idling is off.
   always @(negedge clock) begin
      rsp_ready <= idle_on ? ($urandom_range(99) >= 10) : 1'b1;
   end

   // Track the PC the core reports so programs can be dropped in front of it.
   always @(posedge clock) begin
      if (rsp_valid && rsp_ready) last_pc <= rsp_payload.pc_value;
   end

   // Watchdog: end the run if no beat moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Drive one beat: idle at random, then hold valid until it is taken.
   task automatic send(input logic [1:0] kind, input logic [9:0] addr,
                       input logic [31:0] data);
      req_type p;
      p.req_type = kind;
      p.address = addr;
      p.write_data = data;
      @(negedge clock);
      while (idle_on && $urandom_range(99) < 10) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= p;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      item_count++;
      case (kind)
         REQ_STEP: step_count++;
         REQ_IRQ:  irq_count++;
         default:  mem_count++;
      endcase
   endtask

   // Hold the sender until every beat has been answered, then let the core settle.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   function automatic logic opcode_defined(input logic [4:0] op);
      case (op)
         OP_JMP, OP_JMPI, OP_JMPIG, OP_JMPIL, OP_JMPIE, OP_ADDI, OP_SUBI, OP_ANDI,
         OP_ORI, OP_LDI, OP_LDD, OP_STD, OP_ADD, OP_SUB, OP_AND, OP_OR, OP_LDX,
         OP_STX, OP_NOT, OP_SHL, OP_SHR, OP_SWAP, OP_MULT, OP_STOP: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   // Random word that never decodes as STOP, so the core keeps running.
   function automatic logic [31:0] safe_word();
      logic [31:0] w;
      w = $urandom;
      if (w[31:27] == OP_STOP) w[31] = 1'b0;
      return w;
   endfunction

   // Instruction with random register fields, filler bits and immediate.
   function automatic logic [31:0] make_instr(input logic [4:0] op);
      logic [31:0] w;
      w = $urandom;
      w[31:27] = op;
      return w;
   endfunction

   function automatic logic [4:0] random_opcode();
      logic [4:0] op;
      if ($urandom_range(99) < 8) begin
         // undefined opcode: pick until it misses the decode table
         do op = 5'($urandom_range(31)); while (opcode_defined(op));
      end else begin
         do op = 5'($urandom_range(31)); while (!opcode_defined(op) || op == OP_STOP);
      end
      return op;
   endfunction

   // Load a short program at the current PC, then step through it with noise.
   task automatic program_burst(input int len);
      logic [9:0] base;
      int n_items;
      drain();
      base = last_pc;
      for (int i = 0; i < len; i++)
         send(REQ_WRITE, base + i[9:0], make_instr(random_opcode()));
      n_items = len + $urandom_range(4);
      for (int i = 0; i < n_items; i++) begin
         case ($urandom_range(19))
            0:       send(REQ_IRQ, 10'($urandom), $urandom);
            1:       send(REQ_READ, 10'($urandom), $urandom);
            2:       send(REQ_WRITE, 10'($urandom), safe_word());
            default: send(REQ_STEP, 10'($urandom), $urandom);
         endcase
      end
   endtask

   initial begin
      logic [4:0] op;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Fill memory so no fetch or read ever lands on a word never written.
      idle_on = 1'b0;
      for (int a = 0; a < 1024; a++) send(REQ_WRITE, a[9:0], safe_word());
      idle_on = 1'b1;

      // Directed: data and address extremes, repeated interrupt, halted-free step.
      send(REQ_WRITE, 10'd1023, 32'hFFFF_FFFF);
      send(REQ_READ, 10'd1023, 32'h0);
      send(REQ_WRITE, 10'd0, 32'h8000_0000);
      send(REQ_READ, 10'd0, 32'hFFFF_FFFF);
      send(REQ_WRITE, 10'd1023, 32'h7FFF_FFFF);
      send(REQ_READ, 10'd1023, 32'h0);
      send(REQ_IRQ, 10'd0, 32'h0);
      send(REQ_IRQ, 10'd1023, 32'h0);
      send(REQ_STEP, 10'd0, 32'h0);
      // Write every defined opcode but STOP once, plus one undefined one, then step into them.
      drain();
      for (int i = 0; i < 32; i++) begin
         op = i[4:0];
         if (opcode_defined(op) && op != OP_STOP)
            send(REQ_WRITE, last_pc + i[9:0], make_instr(op));
         else
            send(REQ_WRITE, last_pc + i[9:0], make_instr(OP_LDI));
      end
      send(REQ_WRITE, last_pc + 10'd32, make_instr(random_opcode() | 5'h05) & 32'h2FFF_FFFF);
      for (int i = 0; i < 12; i++) send(REQ_STEP, 10'd0, 32'h0);

      // Random programs; one stretch runs with no idling on either side.
      for (int b = 0; item_count < 1024 + 60 + 450; b++) begin
         idle_on = !(b >= 15 && b < 25);
         program_burst($urandom_range(2, 8));
      end
      idle_on = 1'b1;

      // Halt at the end: STOP, then steps and an interrupt that must do nothing.
      drain();
      send(REQ_WRITE, last_pc, make_instr(OP_STOP));
      send(REQ_STEP, 10'd0, 32'h0);
      send(REQ_STEP, 10'd0, 32'h0);
      send(REQ_IRQ, 10'd0, 32'h0);
      send(REQ_STEP, 10'd0, 32'h0);
      send(REQ_READ, 10'($urandom), 32'h0);
      drain();
      repeat (10) @(posedge clock);

      $display("Covered %0d items: %0d steps, %0d interrupts, %0d memory beats,",
               item_count, step_count, irq_count, mem_count);
      $display("random programs with undefined opcodes and a final STOP.");
      if (fail_count == 0 && outstanding == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
